@@ rtl/grs_pkg.sv @@
package grs_pkg;

  // Field widths of the element and result beats and of the group size
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;

  // Widest buffer index over the supported group range (up to 64 entries)
  localparam int IDX_MAX_W = 6;

  // Configuration port geometry
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE = REG_IDX_W'(0);

  typedef logic signed [DATA_W-1:0] value_t;

  // One flushed group waiting to be drained
  typedef struct packed {
    logic                 bank;
    logic [IDX_MAX_W-1:0] last_idx;
    logic                 list_end;
  } desc_t;

  // Bank handed back to the fill side once its last entry is read
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

@@ rtl/grs_if.sv @@
interface grs_elem_if import grs_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t element_value;
  logic   list_end;

  modport source(output valid, element_value, list_end, input ready);
  modport sink(input valid, element_value, list_end, output ready);
endinterface

interface grs_res_if import grs_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t out_value;
  logic   group_last;
  logic   stream_last;

  modport source(output valid, out_value, group_last, stream_last, input ready);
  modport sink(input valid, out_value, group_last, stream_last, output ready);
endinterface

@@ rtl/grs_ram.sv @@
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/grs_front.sv @@
module grs_front import grs_pkg::*; #(
  parameter int GROUP_MAX = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  grs_elem_if.sink                      element,
  input  logic [CFG_W-1:0]              group_size,
  input  release_t                      rel,
  output logic                          ram_we,
  output logic [$clog2(GROUP_MAX):0]    ram_waddr,
  output value_t                        ram_wdata,
  output logic                          push,
  output desc_t                         push_desc
);

  localparam int IDX_W = $clog2(GROUP_MAX);
  localparam int CNT_W = $clog2(GROUP_MAX + 1);

  logic [IDX_W-1:0] fill;
  logic             wbank;
  logic [1:0]       busy;
  logic [1:0]       busy_next;
  logic [CNT_W-1:0] eff_size;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept;
  logic             flush;

  // Clamp the programmed size into 1..GROUP_MAX
  always_comb begin
    if (group_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (group_size > CFG_W'(GROUP_MAX)) begin
      eff_size = CNT_W'(GROUP_MAX);
    end else begin
      eff_size = group_size[CNT_W-1:0];
    end
  end

  // Hold the stream while the bank being filled is still draining
  assign element.ready = !busy[wbank];
  assign accept        = element.valid && element.ready;
  assign cnt_inc       = CNT_W'(fill) + CNT_W'(1);
  assign flush         = element.list_end || (cnt_inc >= eff_size);

  // Store every accepted beat in the current bank
  assign ram_we    = accept;
  assign ram_waddr = {wbank, fill};
  assign ram_wdata = element.element_value;

  // Hand a finished group to the drain side
  assign push               = accept && flush;
  assign push_desc.bank     = wbank;
  assign push_desc.last_idx = IDX_MAX_W'(fill);
  assign push_desc.list_end = element.list_end;

  // Advance fill position and swap banks on a flush
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      wbank <= 1'b0;
    end else if (accept) begin
      if (flush) begin
        fill  <= '0;
        wbank <= !wbank;
      end else begin
        fill <= fill + IDX_W'(1);
      end
    end
  end

  // Track which banks hold a group not yet read out
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= busy_next;
    end
  end

endmodule

@@ rtl/grs_queue.sv @@
module grs_queue import grs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  head_valid
);

  // One slot per buffer bank
  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  desc_t            slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign head       = slots[rptr];
  assign head_valid = (count != '0);

  // Store descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_desc;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/grs_back.sv @@
module grs_back import grs_pkg::*; #(
  parameter int GROUP_MAX = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  desc_t                      head,
  input  logic                       head_valid,
  output logic                       pop,
  output release_t                   rel,
  output logic                       ram_re,
  output logic [$clog2(GROUP_MAX):0] ram_raddr,
  input  value_t                     ram_rdata,
  grs_res_if.source                  result
);

  localparam int IDX_W = $clog2(GROUP_MAX);

  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] src;
  logic             is_last;
  logic             out_move;
  logic             issue;
  logic             s1_valid;
  logic             s1_group_last;
  logic             s1_stream_last;
  logic             out_valid;

  assign last_idx = head.last_idx[IDX_W-1:0];
  assign src      = last_idx - k;
  assign is_last  = (k == last_idx);

  // Read a new entry only when the read stage will be free
  assign out_move = !out_valid || result.ready;
  assign issue    = head_valid && (!s1_valid || out_move);

  assign ram_re    = issue;
  assign ram_raddr = {head.bank, src};

  // Retire the group and free its bank on the last read
  assign pop       = issue && is_last;
  assign rel.valid = pop;
  assign rel.bank  = head.bank;

  // Walk the group from newest to oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (issue) begin
      if (is_last) begin
        k <= '0;
      end else begin
        k <= k + IDX_W'(1);
      end
    end
  end

  // Read stage: flags travel alongside the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (out_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_group_last  <= is_last;
      s1_stream_last <= is_last && head.list_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid) begin
      result.out_value   <= ram_rdata;
      result.group_last  <= s1_group_last;
      result.stream_last <= s1_stream_last;
    end
  end

  assign result.valid = out_valid;

endmodule

@@ rtl/group_reverse_stream.sv @@
// A group's first result follows its completing beat via the queue, RAM read stage and
// output register. One element and one result per cycle while result.ready is high;
// two buffer banks alternate; the element side stalls only while both hold unread groups.
// Reset (synchronous): clears fill position, bank flags, descriptor queue and output
// valid, and sets group_size to 1; buffer contents are left as they are.
module group_reverse_stream import grs_pkg::*; #(
  parameter int GROUP_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  grs_elem_if.sink              element,
  grs_res_if.source             result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Each bank spans a power-of-two range so {bank, index} stays in bounds
  localparam int RAM_DEPTH = 2 * (2 ** $clog2(GROUP_MAX));
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  logic [CFG_W-1:0]  group_size;
  logic              cfg_wr;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  value_t            ram_wdata;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              push;
  desc_t             push_desc;
  logic              pop;
  desc_t             head;
  logic              head_valid;
  release_t          rel;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_GROUP_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= CFG_W'(1);
    end else if (cfg_wr) begin
      group_size <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_GROUP_SIZE) begin
      prdata = APB_DATA_W'(group_size);
    end
  end

  grs_front #(.GROUP_MAX(GROUP_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .element   (element),
    .group_size(group_size),
    .rel       (rel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_desc (push_desc)
  );

  grs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  grs_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  grs_back #(.GROUP_MAX(GROUP_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .rel       (rel),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

endmodule

@@ tb/sv/group_reverse_stream_test.sv @@
`timescale 1ns / 100ps

module group_reverse_stream_test import grs_pkg::*; ();

  localparam int GROUP_LIMIT  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 220;
  localparam int QUIET_ITEMS  = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    value_t value;
    logic   group_last;
    logic   stream_last;
  } beat_t;

  typedef enum logic {ROW_ELEMENT, ROW_GROUP_SIZE} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] size;
    value_t           value;
    logic             list_end;
    logic             typed;
    beat_t            want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  grs_elem_if element();
  grs_res_if  result();

  group_reverse_stream dut (
    .clk     (clk),
    .rst     (rst),
    .element (element),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Directed beats: extremes and the reset size first, then size changes and short groups
  dir_row_t directed_rows [24] = '{
    '{ROW_ELEMENT,    7'd0,   32'sh7FFFFFFF, 1'b0, 1'b1, '{32'sh7FFFFFFF, 1'b1, 1'b0}},
    '{ROW_ELEMENT,    7'd0,   32'sh80000000, 1'b1, 1'b1, '{32'sh80000000, 1'b1, 1'b1}},
    '{ROW_ELEMENT,    7'd0,   32'sh00000000, 1'b0, 1'b1, '{32'sh00000000, 1'b1, 1'b0}},
    '{ROW_ELEMENT,    7'd0,   32'shFFFFFFFF, 1'b0, 1'b1, '{32'shFFFFFFFF, 1'b1, 1'b0}},
    '{ROW_GROUP_SIZE, 7'd0,   32'sh0,        1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000005, 1'b0, 1'b1, '{32'sh00000005, 1'b1, 1'b0}},
    '{ROW_ELEMENT,    7'd0,   32'shFFFFFFFB, 1'b1, 1'b1, '{32'shFFFFFFFB, 1'b1, 1'b1}},
    '{ROW_GROUP_SIZE, 7'd127, 32'sh0,        1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000001, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000002, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000003, 1'b1, 1'b0, '0},
    '{ROW_GROUP_SIZE, 7'd3,   32'sh0,        1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000010, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000020, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000030, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000040, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000050, 1'b0, 1'b0, '0},
    '{ROW_GROUP_SIZE, 7'd2,   32'sh0,        1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000060, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000070, 1'b1, 1'b0, '0},
    '{ROW_GROUP_SIZE, 7'd64,  32'sh0,        1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh55AA55AA, 1'b1, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'shAA55AA55, 1'b0, 1'b0, '0},
    '{ROW_ELEMENT,    7'd0,   32'sh00000001, 1'b1, 1'b0, '0}
  };

  // Mirror of the group buffer and the size register
  value_t           group_store [GROUP_LIMIT];
  int unsigned      stored;
  logic [CFG_W-1:0] size_setting;
  beat_t            reversed_beats [$];

  int errors = 0;
  int cycles = 0;
  bit idling_on;

  function automatic int unsigned effective_group();
    int unsigned g;
    g = size_setting;
    if (g == 0) g = 1;
    if (g > GROUP_LIMIT) g = GROUP_LIMIT;
    return g;
  endfunction

  // Store one element; on a full group or list end queue the group newest first when push is set
  function automatic void store_and_flush(value_t v, logic last_in_list, bit push);
    int unsigned n;
    beat_t       b;
    group_store[stored] = v;
    stored++;
    if (!last_in_list && stored < effective_group()) return;
    n = stored;
    for (int unsigned k = 0; k < n; k++) begin
      b.value       = group_store[n - 1 - k];
      b.group_last  = (k + 1 == n);
      b.stream_last = (k + 1 == n) && last_in_list;
      if (push) reversed_beats.push_back(b);
    end
    stored = 0;
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return value_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s at cycle %0d: got %h, expected %h", field, cycles, got, want);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each result beat against the oldest expected beat
  always @(posedge clk) begin
    beat_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (reversed_beats.size() == 0) begin
        report_mismatch("unexpected beat", result.out_value, '0);
      end else begin
        want = reversed_beats.pop_front();
        if (result.out_value !== want.value)
          report_mismatch("out_value", result.out_value, want.value);
        if (result.group_last !== want.group_last)
          report_mismatch("group_last", 32'(result.group_last), 32'(want.group_last));
        if (result.stream_last !== want.stream_last)
          report_mismatch("stream_last", 32'(result.stream_last), 32'(want.stream_last));
      end
    end
  end

  // Result side: stall in random bursts while idling is on
  initial begin
    int unsigned hold;
    bit          level;
    hold  = 0;
    level = 1'b1;
    result.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (!idling_on) begin
        result.ready <= 1'b1;
      end else begin
        if (hold == 0) begin
          level = ($urandom_range(0, 2) != 0);
          hold  = level ? $urandom_range(1, 16) : $urandom_range(1, 8);
        end
        hold--;
        result.ready <= level;
      end
    end
  end

  // Present one element beat, hold until taken, then maybe pause
  task automatic send_element(value_t v, logic last_in_list, bit typed, beat_t want);
    element.valid         <= 1'b1;
    element.element_value <= v;
    element.list_end      <= last_in_list;
    do @(posedge clk); while (element.ready !== 1'b1);
    store_and_flush(v, last_in_list, !typed);
    if (typed) reversed_beats.push_back(want);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      element.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Drop valid, wait until every expected beat has come, then let the design run on idle
  task automatic settle();
    element.valid <= 1'b0;
    while (reversed_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write group_size, then read it back
  task automatic set_group_size(logic [CFG_W-1:0] size);
    logic [APB_DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_GROUP_SIZE, 2'b00};
    pwdata  <= {$urandom} & ~APB_DATA_W'(7'h7F) | APB_DATA_W'(size);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    size_setting = size;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    if (readback[CFG_W-1:0] !== size)
      report_mismatch("group_size readback", readback, 32'(size));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [CFG_W-1:0] phase_sizes [4];
    logic [CFG_W-1:0] size;
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      plen;
    logic             last_in_list;

    phase_sizes = '{7'd127, 7'd0, 7'd2, 7'd65};
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    element.valid         <= 1'b0;
    element.element_value <= '0;
    element.list_end      <= 1'b0;
    stored       = 0;
    size_setting = 7'd1;
    idling_on    = 1'b1;

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_GROUP_SIZE) begin
        settle();
        set_group_size(directed_rows[i].size);
      end else begin
        send_element(directed_rows[i].value, directed_rows[i].list_end,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each at its own group size; the first, saturating, sends over a full group
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 4)
        size = phase_sizes[phase];
      else if ($urandom_range(0, 3) != 0)
        size = CFG_W'($urandom_range(1, 8));
      else
        size = CFG_W'($urandom_range(9, GROUP_LIMIT));
      settle();
      set_group_size(size);
      idling_on = (phase % 3 != 2);
      plen = (phase == 0) ? GROUP_LIMIT + $urandom_range(1, 6) : $urandom_range(10, 30);
      for (int unsigned j = 0; j < plen && sent < RANDOM_ITEMS; j++) begin
        if (sent >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
        if (phase == 0)
          last_in_list = (j == plen - 1);
        else
          last_in_list = ($urandom_range(0, 9) == 0);
        if (sent == RANDOM_ITEMS - 1) last_in_list = 1'b1;
        send_element(pick_value(), last_in_list, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    // Drain and decide
    settle();
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/grs_pkg.sv
rtl/grs_if.sv
rtl/grs_ram.sv
rtl/grs_front.sv
rtl/grs_queue.sv
rtl/grs_back.sv
rtl/group_reverse_stream.sv
tb/sv/group_reverse_stream_test.sv
